>>> src/modbus_rtu_sensor_poll_fsm_defines.svh
// ----------------------------------------------------------------------------
// modbus rtu sensor poll assertion macros
// shared concurrent assertion forms for the poll block
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SENSOR_POLL_FSM_DEFINES_SVH
`define MODBUS_RTU_SENSOR_POLL_FSM_DEFINES_SVH

// same-cycle implication
`define MBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mbpoll_pkg.sv
// ----------------------------------------------------------------------------
// mbpoll_pkg
// types, codes and constants for the modbus rtu sensor poll block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbpoll_pkg;

    localparam int RESPONSE_BYTES = 11;
    localparam int FRAME_BYTES    = 8;
    localparam int RX_CNT_W       = $clog2(RESPONSE_BYTES + 1);
    localparam int BEAT_W         = $clog2(FRAME_BYTES);

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [7:0]  SLAVE_ID      = 8'h01;
    localparam logic [7:0]  FUNC_READ     = 8'h03;
    localparam logic [7:0]  BYTE_COUNT    = 8'h06;

    typedef enum logic [2:0] {
        ST_INIT       = 3'd0,
        ST_IDLE       = 3'd1,
        ST_REQUESTING = 3'd2,
        ST_WAITING    = 3'd3,
        ST_PARSING    = 3'd4,
        ST_DONE       = 3'd5,
        ST_ERROR      = 3'd6
    } t_fsm_state;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_REQUEST = 3'd1,
        CMD_UPDATE  = 3'd2,
        CMD_RX_BYTE = 3'd3,
        CMD_READ    = 3'd4,
        CMD_TICK    = 3'd5
    } t_command;

    typedef struct packed {
        logic [2:0]  fsm_code;
        logic        request_accepted;
        logic        data_valid;
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic [15:0] conductivity;
        logic        frame;
    } t_result;

    // fixed fc03 request: slave 1, address 0, 3 registers, crc
    function automatic logic [7:0] frame_byte(input logic [BEAT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h00;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h03;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hCB;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> src/mbpoll_core.sv
// ----------------------------------------------------------------------------
// mbpoll_core
// poll state machine, receive buffer, timeout counter and latched words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbpoll_core
    import mbpoll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_take,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_rx_data,
    input  logic        i_tx_fail,
    output t_result     o_res
);

    t_fsm_state          r_state, n_state;
    logic [15:0]         r_timeout_ms;
    logic [15:0]         r_timeout_left, n_timeout_left;
    logic [RX_CNT_W-1:0] r_rx_count, n_rx_count;
    logic [7:0]          r_rx_buf [RESPONSE_BYTES];
    logic                r_valid, n_valid;
    logic [15:0]         r_hum, n_hum;
    logic [15:0]         r_temp, n_temp;
    logic [15:0]         r_cond, n_cond;

    t_command cmd;
    logic     rx_full;
    logic     hdr_ok;
    logic     rx_wr;

    assign cmd     = t_command'(i_command);
    assign rx_full = (r_rx_count >= RX_CNT_W'(RESPONSE_BYTES));
    assign hdr_ok  = rx_full && (r_rx_buf[0] == SLAVE_ID) && (r_rx_buf[1] == FUNC_READ)
                     && (r_rx_buf[2] == BYTE_COUNT);
    assign rx_wr   = i_take && (cmd == CMD_RX_BYTE) && (r_state == ST_WAITING) && !rx_full;

    // next state
    always_comb begin
        n_state = r_state;
        case (cmd)
            CMD_START: begin
                n_state = ST_INIT;
            end
            CMD_REQUEST: begin
                if (r_state inside {ST_IDLE, ST_DONE}) begin
                    n_state = ST_REQUESTING;
                end
            end
            CMD_UPDATE: begin
                case (r_state)
                    ST_INIT:       n_state = ST_IDLE;
                    ST_REQUESTING: n_state = i_tx_fail ? ST_ERROR : ST_WAITING;
                    ST_WAITING: begin
                        if (rx_full) begin
                            n_state = ST_PARSING;
                        end else if (r_timeout_left == 16'd0) begin
                            n_state = ST_ERROR;
                        end
                    end
                    ST_PARSING:    n_state = hdr_ok ? ST_DONE : ST_ERROR;
                    ST_ERROR:      n_state = ST_INIT;
                    default:       n_state = r_state;
                endcase
            end
            CMD_READ: begin
                if (r_state == ST_DONE) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = r_state;
        endcase
    end

    // datapath next values
    always_comb begin
        n_rx_count     = r_rx_count;
        n_timeout_left = r_timeout_left;
        n_valid        = r_valid;
        n_hum          = r_hum;
        n_temp         = r_temp;
        n_cond         = r_cond;
        case (cmd)
            CMD_START: begin
                n_rx_count = '0;
            end
            CMD_UPDATE: begin
                case (r_state)
                    ST_INIT: begin
                        n_valid    = 1'b0;
                        n_rx_count = '0;
                    end
                    ST_REQUESTING: begin
                        if (!i_tx_fail) begin
                            n_timeout_left = r_timeout_ms;
                            n_rx_count     = '0;
                        end
                    end
                    ST_PARSING: begin
                        if (hdr_ok) begin
                            n_valid = 1'b1;
                            n_hum   = {r_rx_buf[3], r_rx_buf[4]};
                            n_temp  = {r_rx_buf[5], r_rx_buf[6]};
                            n_cond  = {r_rx_buf[7], r_rx_buf[8]};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_RX_BYTE: begin
                if (rx_wr) begin
                    n_rx_count = RX_CNT_W'(r_rx_count + 1'b1);
                end
            end
            CMD_TICK: begin
                if (r_state == ST_WAITING && r_timeout_left != 16'd0) begin
                    n_timeout_left = r_timeout_left - 16'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // result of this transaction
    always_comb begin
        o_res.fsm_code         = (cmd == CMD_READ) ? r_state : n_state;
        o_res.request_accepted = (cmd == CMD_REQUEST) && (r_state inside {ST_IDLE, ST_DONE});
        o_res.data_valid       = n_valid;
        o_res.humidity         = n_valid ? n_hum  : 16'd0;
        o_res.temperature      = n_valid ? n_temp : 16'd0;
        o_res.conductivity     = n_valid ? n_cond : 16'd0;
        o_res.frame            = (cmd == CMD_UPDATE) && (r_state == ST_REQUESTING)
                                 && !i_tx_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_timeout_ms   <= TIMEOUT_RESET;
            r_timeout_left <= '0;
            r_rx_count     <= '0;
            r_valid        <= 1'b0;
            r_hum          <= '0;
            r_temp         <= '0;
            r_cond         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout_ms <= i_cfg_data;
            end
            if (i_take) begin
                r_state        <= n_state;
                r_timeout_left <= n_timeout_left;
                r_rx_count     <= n_rx_count;
                r_valid        <= n_valid;
                r_hum          <= n_hum;
                r_temp         <= n_temp;
                r_cond         <= n_cond;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RESPONSE_BYTES; i++) begin
            if (rx_wr && r_rx_count == RX_CNT_W'(i)) begin
                r_rx_buf[i] <= i_rx_data;
            end
        end
    end

endmodule

>>> src/mbpoll_out.sv
// ----------------------------------------------------------------------------
// mbpoll_out
// result register with request frame sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbpoll_out
    import mbpoll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    input  logic        i_stall,
    output logic        o_valid,
    output logic        o_last,
    output logic [2:0]  o_fsm_code,
    output logic        o_request_accepted,
    output logic        o_data_valid,
    output logic [15:0] o_humidity_tenths,
    output logic [15:0] o_temperature_tenths,
    output logic [15:0] o_conductivity_raw,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte
);

    logic              r_valid;
    logic              r_last;
    logic              r_frame;
    logic [BEAT_W-1:0] r_beat;
    t_result           r_res;

    logic take;

    assign take = r_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_frame <= 1'b0;
            r_beat  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_frame <= i_res.frame;
            r_last  <= !i_res.frame;
            r_beat  <= '0;
        end else if (take) begin
            if (r_frame && !r_last) begin
                r_beat <= BEAT_W'(r_beat + 1'b1);
                r_last <= (r_beat == BEAT_W'(FRAME_BYTES - 2));
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid              = r_valid;
    assign o_last               = r_last;
    assign o_fsm_code           = r_res.fsm_code;
    assign o_request_accepted   = r_res.request_accepted;
    assign o_data_valid         = r_res.data_valid;
    assign o_humidity_tenths    = r_res.humidity;
    assign o_temperature_tenths = r_res.temperature;
    assign o_conductivity_raw   = r_res.conductivity;
    assign o_tx_valid           = r_frame;
    assign o_tx_byte            = r_frame ? frame_byte(r_beat) : 8'h00;

endmodule

>>> src/modbus_rtu_sensor_poll_fsm.sv
// ----------------------------------------------------------------------------
// modbus_rtu_sensor_poll_fsm
// modbus rtu fc03 master polling one sensor for three holding registers
// ----------------------------------------------------------------------------
// input channel i_valid / o_stall carries one command transaction: start,
// request, update step, received byte, read state or millisecond tick.
// output channel o_valid / i_stall carries status results: state code,
// request flag, latched humidity, temperature and conductivity words, and
// a request frame byte on tx_valid, with o_last on the final result.
// a command is applied to the state at the edge it is accepted and its
// result shows on the output the next cycle.
// one command is accepted per cycle when not stalled; an update step that
// sends the frame yields 8 results, one per cycle when not stalled, and
// holds off input for the first 7 of them, the next command is taken with
// the eighth byte (set by the frame sequencer in the result register).
// when the receiver stalls, the result register holds and o_stall rises
// once it is full, so no transaction is lost.
// timeout_ms is written through i_cfg_we / i_cfg_data, reset value 500.
// synchronous reset puts the machine in idle with no valid data and an
// empty output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_rtu_sensor_poll_fsm_defines.svh"

module modbus_rtu_sensor_poll_fsm
    import mbpoll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_rx_data,
    input  logic        i_tx_fail,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_fsm_code,
    output logic        o_request_accepted,
    output logic        o_data_valid,
    output logic [15:0] o_humidity_tenths,
    output logic [15:0] o_temperature_tenths,
    output logic [15:0] o_conductivity_raw,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_last
);

    t_result res;
    logic    take;

    assign o_stall = o_valid && !(!i_stall && o_last);
    assign take    = i_valid && !o_stall;

    mbpoll_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_command  (i_command),
        .i_rx_data  (i_rx_data),
        .i_tx_fail  (i_tx_fail),
        .o_res      (res)
    );

    mbpoll_out u_out (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_load               (take),
        .i_res                (res),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_last               (o_last),
        .o_fsm_code           (o_fsm_code),
        .o_request_accepted   (o_request_accepted),
        .o_data_valid         (o_data_valid),
        .o_humidity_tenths    (o_humidity_tenths),
        .o_temperature_tenths (o_temperature_tenths),
        .o_conductivity_raw   (o_conductivity_raw),
        .o_tx_valid           (o_tx_valid),
        .o_tx_byte            (o_tx_byte)
    );

    `MBP_ASSERT_IMPL(a_burst_holds_input, i_clk, i_rst_n, o_valid && o_tx_valid && !o_last, o_stall, "input taken during frame burst")
    `MBP_ASSERT_IMPL(a_frame_in_waiting, i_clk, i_rst_n, o_valid && o_tx_valid, o_fsm_code == ST_WAITING && !o_request_accepted, "frame byte outside waiting")
    `MBP_ASSERT_IMPL(a_words_masked, i_clk, i_rst_n, o_valid && !o_data_valid, o_humidity_tenths == 16'd0 && o_temperature_tenths == 16'd0 && o_conductivity_raw == 16'd0, "words shown without valid data")
    `MBP_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_valid && !i_stall && o_tx_valid && !o_last, o_valid && o_tx_valid, "frame burst cut short")

endmodule

>>> tb/tb_modbus_rtu_sensor_poll_fsm.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_sensor_poll_fsm
// drives command transactions into the fc03 sensor poll master and checks
// every status result against a cycle-free model of the poll state machine,
// first from a directed table, then from random polls across timeout settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modbus_rtu_sensor_poll_fsm;
    import mbpoll_pkg::*;

    localparam int          CYCLE_LIMIT   = 300000;
    localparam logic [2:0]  CMD_UNDEFINED = 3'd6;
    localparam logic [63:0] REQ_FRAME     = 64'h01_03_00_00_00_03_05_CB;

    typedef struct packed {
        logic [2:0]  fsm_code;
        logic        accepted;
        logic        data_valid;
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic [15:0] conductivity;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
    } poll_status_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  cmd;
        logic [7:0]  rxb;
        logic        fail;
        logic [15:0] cfg;
        t_fsm_state  code;
        logic        acc;
        logic        dv;
    } dir_row_t;

    localparam int DIR_ROWS = 32;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_TYPED, CMD_READ,      8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_UNDEFINED, 8'hFF, 1'b1, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_RX_BYTE,   8'hFF, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_TICK,      8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_REQUEST,   8'h00, 1'b0, 16'd0, ST_REQUESTING, 1'b1, 1'b0},
        '{ROW_TYPED, CMD_REQUEST,   8'h00, 1'b0, 16'd0, ST_REQUESTING, 1'b0, 1'b0},
        '{ROW_TYPED, CMD_UPDATE,    8'h00, 1'b1, 16'd0, ST_ERROR,      1'b0, 1'b0},
        '{ROW_TYPED, CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_INIT,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_REQUEST,   8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h01, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h03, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h06, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'hFF, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'hFF, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'hFF, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'h5A, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_RX_BYTE,   8'hA5, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_RX_BYTE,   8'h00, 1'b0, 16'd0, ST_WAITING,    1'b0, 1'b0},
        '{ROW_TYPED, CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_PARSING,    1'b0, 1'b0},
        '{ROW_ITEM,  CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_READ,      8'h00, 1'b0, 16'd0, ST_DONE,       1'b0, 1'b1},
        '{ROW_CFG,   CMD_START,     8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_REQUEST,   8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_ITEM,  CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_IDLE,       1'b0, 1'b0},
        '{ROW_TYPED, CMD_TICK,      8'h00, 1'b0, 16'd0, ST_WAITING,    1'b0, 1'b1},
        '{ROW_TYPED, CMD_UPDATE,    8'h00, 1'b0, 16'd0, ST_ERROR,      1'b0, 1'b1},
        '{ROW_TYPED, CMD_START,     8'h00, 1'b0, 16'd0, ST_INIT,       1'b0, 1'b1}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_command;
    logic [7:0]  i_rx_data;
    logic        i_tx_fail;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_fsm_code;
    logic        o_request_accepted;
    logic        o_data_valid;
    logic [15:0] o_humidity_tenths;
    logic [15:0] o_temperature_tenths;
    logic [15:0] o_conductivity_raw;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_last;

    // poll machine model
    t_fsm_state  m_state;
    logic [7:0]  m_rx [RESPONSE_BYTES];
    int          m_count;
    logic        m_valid;
    logic [15:0] m_hum;
    logic [15:0] m_temp;
    logic [15:0] m_cond;
    logic [15:0] m_left;
    logic [15:0] m_timeout;

    poll_status_t status_due [$];

    logic        typed_now;
    t_fsm_state  typed_code;
    logic        typed_acc;
    logic        typed_dv;

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_left;
    int items_sent;
    int results_checked;
    int frames_sent;
    int replies_ok;
    int error_trips;
    int mismatch_count;
    int cycle_count;

    modbus_rtu_sensor_poll_fsm uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_command           (i_command),
        .i_rx_data           (i_rx_data),
        .i_tx_fail           (i_tx_fail),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_fsm_code          (o_fsm_code),
        .o_request_accepted  (o_request_accepted),
        .o_data_valid        (o_data_valid),
        .o_humidity_tenths   (o_humidity_tenths),
        .o_temperature_tenths(o_temperature_tenths),
        .o_conductivity_raw  (o_conductivity_raw),
        .o_tx_valid          (o_tx_valid),
        .o_tx_byte           (o_tx_byte),
        .o_last              (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     status_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // receiver side: random stall, or a long hold-off when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                i_stall = ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                      results_checked, name, got, want));
        end
    endtask

    task automatic push_status(input logic [2:0] code, input logic acc, input logic txv,
                               input logic [7:0] txb, input logic fin);
        poll_status_t s;
        s.fsm_code     = code;
        s.accepted     = acc;
        s.data_valid   = m_valid;
        s.humidity     = m_valid ? m_hum : 16'h0000;
        s.temperature  = m_valid ? m_temp : 16'h0000;
        s.conductivity = m_valid ? m_cond : 16'h0000;
        s.tx_valid     = txv;
        s.tx_byte      = txv ? txb : 8'h00;
        s.last         = fin;
        status_due.push_back(s);
    endtask

    task automatic predict_poll_step(input logic [2:0] cmd, input logic [7:0] rxb,
                                     input logic fail);
        t_fsm_state shown;
        logic       acc;
        logic       frame_out;
        int         i;
        shown = m_state;
        acc = 1'b0;
        frame_out = 1'b0;
        case (cmd)
            CMD_START: begin
                m_count = 0;
                m_state = ST_INIT;
            end
            CMD_REQUEST: begin
                if (m_state == ST_IDLE || m_state == ST_DONE) begin
                    m_state = ST_REQUESTING;
                    acc = 1'b1;
                end
            end
            CMD_UPDATE: begin
                case (m_state)
                    ST_INIT: begin
                        m_valid = 1'b0;
                        m_count = 0;
                        m_state = ST_IDLE;
                    end
                    ST_REQUESTING: begin
                        if (fail) begin
                            m_state = ST_ERROR;
                            error_trips++;
                        end else begin
                            m_left = m_timeout;
                            m_count = 0;
                            m_state = ST_WAITING;
                            frame_out = 1'b1;
                        end
                    end
                    ST_WAITING: begin
                        if (m_count >= RESPONSE_BYTES) begin
                            m_state = ST_PARSING;
                        end else if (m_left == 16'd0) begin
                            m_state = ST_ERROR;
                            error_trips++;
                        end
                    end
                    ST_PARSING: begin
                        if (m_count >= RESPONSE_BYTES && m_rx[0] == SLAVE_ID &&
                            m_rx[1] == FUNC_READ && m_rx[2] == BYTE_COUNT) begin
                            m_hum   = {m_rx[3], m_rx[4]};
                            m_temp  = {m_rx[5], m_rx[6]};
                            m_cond  = {m_rx[7], m_rx[8]};
                            m_valid = 1'b1;
                            m_state = ST_DONE;
                            replies_ok++;
                        end else begin
                            m_state = ST_ERROR;
                            error_trips++;
                        end
                    end
                    ST_ERROR: begin
                        m_state = ST_INIT;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_RX_BYTE: begin
                if (m_state == ST_WAITING && m_count < RESPONSE_BYTES) begin
                    m_rx[m_count] = rxb;
                    m_count++;
                end
            end
            CMD_READ: begin
                if (m_state == ST_DONE) begin
                    m_state = ST_IDLE;
                end
            end
            CMD_TICK: begin
                if (m_state == ST_WAITING && m_left != 16'd0) begin
                    m_left--;
                end
            end
            default: begin
            end
        endcase
        if (frame_out) begin
            frames_sent++;
            for (i = 0; i < FRAME_BYTES; i++) begin
                push_status(m_state, 1'b0, 1'b1, REQ_FRAME[63 - 8 * i -: 8],
                            i == FRAME_BYTES - 1);
            end
        end else if (cmd == CMD_READ) begin
            push_status(shown, 1'b0, 1'b0, 8'h00, 1'b1);
        end else begin
            push_status(m_state, acc, 1'b0, 8'h00, 1'b1);
        end
    endtask

    // compare results, track config writes, predict accepted transactions
    always @(posedge i_clk) begin
        poll_status_t got;
        poll_status_t due;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_fsm_code, o_request_accepted, o_data_valid, o_humidity_tenths,
                        o_temperature_tenths, o_conductivity_raw, o_tx_valid, o_tx_byte,
                        o_last};
                if (status_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, state code %0d",
                                              o_fsm_code));
                end else begin
                    due = status_due.pop_front();
                    check_field("fsm_code", 16'(got.fsm_code), 16'(due.fsm_code));
                    check_field("request_accepted", 16'(got.accepted), 16'(due.accepted));
                    check_field("data_valid", 16'(got.data_valid), 16'(due.data_valid));
                    check_field("humidity", got.humidity, due.humidity);
                    check_field("temperature", got.temperature, due.temperature);
                    check_field("conductivity", got.conductivity, due.conductivity);
                    check_field("tx_valid", 16'(got.tx_valid), 16'(due.tx_valid));
                    check_field("tx_byte", 16'(got.tx_byte), 16'(due.tx_byte));
                    check_field("last", 16'(got.last), 16'(due.last));
                end
                results_checked++;
            end
            if (i_cfg_we) begin
                m_timeout = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                predict_poll_step(i_command, i_rx_data, i_tx_fail);
                if (typed_now) begin
                    due = status_due.pop_back();
                    due.fsm_code   = typed_code;
                    due.accepted   = typed_acc;
                    due.data_valid = typed_dv;
                    status_due.push_back(due);
                end
            end
        end
    end

    // one command transaction; called and returns at a falling edge
    task automatic send_command(input logic [2:0] cmd, input logic [7:0] rxb,
                                input logic fail);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_command = cmd;
        i_rx_data = rxb;
        i_tx_fail = fail;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        items_sent++;
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (status_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // request, frame, reply bytes with ticks mixed in, parse and read back
    task automatic run_sensor_poll();
        int         n_bytes;
        int         b;
        logic [7:0] rxb;
        if (m_state != ST_IDLE && m_state != ST_DONE) begin
            send_command(CMD_START, rand_byte(), 1'($urandom_range(0, 1)));
            send_command(CMD_UPDATE, rand_byte(), 1'($urandom_range(0, 1)));
        end
        send_command(CMD_REQUEST, rand_byte(), 1'($urandom_range(0, 1)));
        send_command(CMD_UPDATE, rand_byte(), $urandom_range(0, 9) == 0);
        n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : RESPONSE_BYTES;
        for (b = 0; b < n_bytes; b++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_command(CMD_TICK, rand_byte(), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_command(CMD_UPDATE, rand_byte(), 1'($urandom_range(0, 1)));
            end
            rxb = rand_byte();
            if ($urandom_range(0, 9) != 0) begin
                if (b == 0) rxb = SLAVE_ID;
                if (b == 1) rxb = FUNC_READ;
                if (b == 2) rxb = BYTE_COUNT;
            end
            send_command(CMD_RX_BYTE, rxb, 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(2, 3)) begin
            send_command(CMD_UPDATE, rand_byte(), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) < 7) begin
            send_command(CMD_READ, rand_byte(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random_phase(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                end
            end else begin
                run_sensor_poll();
            end
        end
    endtask

    initial begin
        int r;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 16'h0000;
        i_valid    = 1'b0;
        i_command  = CMD_START;
        i_rx_data  = 8'h00;
        i_tx_fail  = 1'b0;
        typed_now  = 1'b0;
        typed_code = ST_IDLE;
        typed_acc  = 1'b0;
        typed_dv   = 1'b0;
        hold_left  = 0;
        m_state    = ST_IDLE;
        m_count    = 0;
        m_valid    = 1'b0;
        m_hum      = 16'h0000;
        m_temp     = 16'h0000;
        m_cond     = 16'h0000;
        m_left     = 16'h0000;
        m_timeout  = TIMEOUT_RESET;
        for (r = 0; r < RESPONSE_BYTES; r++) begin
            m_rx[r] = 8'h00;
        end
        snd_idle_pct = 16;
        rcv_idle_pct = 66;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                write_timeout(dir_table[r].cfg);
            end else begin
                typed_now  = (dir_table[r].kind == ROW_TYPED);
                typed_code = dir_table[r].code;
                typed_acc  = dir_table[r].acc;
                typed_dv   = dir_table[r].dv;
                send_command(dir_table[r].cmd, dir_table[r].rxb, dir_table[r].fail);
                typed_now  = 1'b0;
            end
        end

        write_timeout(16'd1);
        run_random_phase(40);
        write_timeout(16'hFFFF);
        run_random_phase(40);

        snd_idle_pct = 66;
        rcv_idle_pct = 16;
        write_timeout(16'($urandom_range(3, 12)));
        run_random_phase(45);
        write_timeout(16'd0);
        run_random_phase(30);

        // no idling; long receiver hold-off at the start backs up the block
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_timeout(TIMEOUT_RESET);
        hold_left = 80;
        run_random_phase(50);
        write_timeout(16'($urandom_range(2, 8)));
        run_random_phase(40);

        wait_drained();
        $display("covered %0d command transactions, %0d status results, %0d request frames",
                 items_sent, results_checked, frames_sent);
        $display("latched %0d good replies, entered error %0d times, %0d mismatches",
                 replies_ok, error_trips, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
